/* rtl/core/bitmap_first_fit_block_allocator_assert.svh */
// Assertion macros for the bitmap first-fit block allocator.
// Used by the allocator top level in rtl/core; expects i_clk and i_rst_n in scope.
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only while out of reset.
`define BFFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define BFFA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BFFA_ASSERT(lbl, prop, msg)
`define BFFA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/core/bffa_pkg.sv */
// Package for the bitmap first-fit block allocator: beat types, status codes,
// fixed sizes. No dependencies.
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int unsigned BLOCK_BYTES  = 32;
    localparam int unsigned BLOCK_SHIFT  = 5;
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned WORD_BITS    = 64;
    localparam int unsigned CHUNK_BITS   = 8;
    localparam int unsigned CHUNK_SHIFT  = 3;
    localparam int unsigned CHUNKS       = WORD_BITS / CHUNK_BITS;
    // (2^18 - 1 + header + block - 1) / block fits in 14 bits
    localparam int unsigned NEED_W       = 14;

    localparam logic       MODE_ALLOC = 1'b0;
    localparam logic       MODE_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OOM   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [17:0] request_bytes;
        logic [11:0] start_block;
        logic [12:0] block_count;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] run_start;
        logic [12:0] run_blocks;
        logic [12:0] free_blocks_left;
    } t_out;

    typedef struct packed {
        logic              hit;
        logic [NEED_W-1:0] run;
    } t_scan;

endpackage

/* rtl/core/bffa_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bffa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bffa_scan.sv */
// Shared run-length unit: walks one 8-bit chunk of a map word, carrying the
// free-run length and its first block. Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_scan #(
    parameter int BW = 12
) (
    input  logic [bffa_pkg::CHUNK_BITS-1:0] i_bits,
    input  logic [BW-1:0]                   i_base,
    input  logic [bffa_pkg::NEED_W-1:0]     i_run,
    input  logic [bffa_pkg::NEED_W-1:0]     i_need,
    input  logic [BW-1:0]                   i_first,
    output bffa_pkg::t_scan                 o_res,
    output logic [BW-1:0]                   o_first
);

    always_comb begin
        logic [bffa_pkg::NEED_W-1:0] v_run;
        logic [BW-1:0]               v_first;
        logic                        v_hit;
        v_run   = i_run;
        v_first = i_first;
        v_hit   = 1'b0;
        for (int j = 0; j < bffa_pkg::CHUNK_BITS; j++) begin
            if (!v_hit) begin
                if (i_bits[j]) begin
                    v_run = '0;
                end else begin
                    if (v_run == '0) begin
                        v_first = {i_base[BW-1:bffa_pkg::CHUNK_SHIFT],
                                   bffa_pkg::CHUNK_SHIFT'(j)};
                    end
                    v_run = v_run + bffa_pkg::NEED_W'(1);
                    if (v_run == i_need) begin
                        v_hit = 1'b1;
                    end
                end
            end
        end
        o_res.hit = v_hit;
        o_res.run = v_run;
        o_first   = v_first;
    end

endmodule

/* rtl/core/bffa_mask.sv */
// Read-modify-write merge for one map word: sets or clears the bits of a block
// range that fall inside the word. Depends on bffa_pkg.
`timescale 1ns / 1ps

module bffa_mask #(
    parameter int BW = 12
) (
    input  logic [BW-7:0]                  i_word,
    input  logic [BW-1:0]                  i_lo,
    input  logic [BW-1:0]                  i_hi,
    input  logic                           i_set,
    input  logic [bffa_pkg::WORD_BITS-1:0] i_rdata,
    output logic [bffa_pkg::WORD_BITS-1:0] o_wdata
);

    logic [5:0]                     w_lo_bit;
    logic [5:0]                     w_hi_bit;
    logic [bffa_pkg::WORD_BITS-1:0] w_mask;

    assign w_lo_bit = (i_word == i_lo[BW-1:6]) ? i_lo[5:0] : 6'd0;
    assign w_hi_bit = (i_word == i_hi[BW-1:6]) ? i_hi[5:0] : 6'd63;
    assign w_mask   = ({bffa_pkg::WORD_BITS{1'b1}} << w_lo_bit)
                    & ({bffa_pkg::WORD_BITS{1'b1}} >> (6'd63 - w_hi_bit));
    assign o_wdata  = i_set ? (i_rdata | w_mask) : (i_rdata & ~w_mask);

endmodule

/* rtl/core/bitmap_first_fit_block_allocator.sv */
// Bitmap first-fit block allocator, top level: sequencer, free count, map RAM.
// Depends on bffa_pkg, bffa_ram, bffa_scan, bffa_mask and the assert header.
//
//   channel | valid   | stall   | payload                | direction
//   --------+---------+---------+------------------------+----------
//   request | i_valid | o_stall | i_item   (bffa_pkg::t_in)  | in
//   result  | o_valid | i_stall | o_result (bffa_pkg::t_out) | out
//
// Sequence: a request is taken only in idle; one result beat per request.
//   Rejected allocate or out-of-range free: straight from idle to the done state.
//   Allocate: per map word searched, a read, then a skip of a full word or a
//   chunk-by-chunk walk; then a read and a write per word marked; then done.
//   The 8-block chunk walk of the shared scan unit takes most of the search.
//   Free: a read-modify-write of the map RAM per map word touched.
// Reset: a clearing pass writes zero to every map word with o_stall high;
//   the free count resets to POOL_BLOCKS.
// Stalls: the result register holds a finished beat while the next request
//   is taken; a new result waits in the done state until that beat leaves.
`timescale 1ns / 1ps
`include "bitmap_first_fit_block_allocator_assert.svh"

module bitmap_first_fit_block_allocator #(
    parameter int POOL_BLOCKS = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bffa_pkg::t_in  i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output bffa_pkg::t_out o_result
);

    localparam int MAP_WORDS  = POOL_BLOCKS / 64;
    localparam int MAP_BLOCKS = MAP_WORDS * 64;
    localparam int WAW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW         = WAW + 6;
    localparam int FCW        = $clog2(POOL_BLOCKS + 1);
    localparam int NW         = bffa_pkg::NEED_W;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_SRD,
        ST_SCAN,
        ST_MRD,
        ST_MWR,
        ST_DONE
    } t_state;

    t_state                  r_state;
    logic [WAW-1:0]          r_word;
    logic [bffa_pkg::CHUNK_SHIFT-1:0] r_chunk;
    logic [FCW-1:0]          r_free;
    logic [NW-1:0]           r_need;
    logic [NW-1:0]           r_run;
    logic [BW-1:0]           r_first;
    logic [BW-1:0]           r_lo;
    logic [BW-1:0]           r_hi;
    logic                    r_set;
    bffa_pkg::t_out          r_res;
    bffa_pkg::t_out          r_out;
    logic                    r_out_valid;

    // Request decode.
    logic [31:0]             n_bytes;
    logic [NW-1:0]           n_need;
    logic [31:0]             n_rel_sum;
    logic [FCW-1:0]          n_free_rel;
    logic [31:0]             n_end;
    logic [BW-1:0]           n_rel_last;
    logic                    n_in_pool;
    logic                    n_in_map;

    // Map RAM and shared units.
    logic                    w_ram_we;
    logic                    w_ram_re;
    logic [bffa_pkg::WORD_BITS-1:0] w_rdata;
    logic [bffa_pkg::WORD_BITS-1:0] w_merge;
    logic [bffa_pkg::WORD_BITS-1:0] w_wdata;
    logic [bffa_pkg::CHUNK_BITS-1:0] w_chunk_bits;
    logic [BW-1:0]           w_chunk_base;
    bffa_pkg::t_scan         w_scan;
    logic [BW-1:0]           w_scan_first;
    logic [BW-1:0]           w_alloc_hi;
    logic [FCW-1:0]          w_free_alloc;
    logic                    w_last_word;

    // Header added, then round up to whole blocks.
    assign n_bytes    = 32'(i_item.request_bytes) + bffa_pkg::HEADER_BYTES;
    assign n_need     = NW'((n_bytes + (bffa_pkg::BLOCK_BYTES - 1))
                            >> bffa_pkg::BLOCK_SHIFT);

    // Free: return the count, saturating at the pool size.
    assign n_rel_sum  = 32'(r_free) + 32'(i_item.block_count);
    assign n_free_rel = (n_rel_sum > 32'(POOL_BLOCKS)) ? FCW'(POOL_BLOCKS)
                                                       : FCW'(n_rel_sum);
    assign n_in_pool  = 32'(i_item.start_block) < 32'(POOL_BLOCKS);
    assign n_in_map   = 32'(i_item.start_block) < 32'(MAP_BLOCKS);
    // Clip the cleared range at the end of the mapped pool.
    assign n_end      = 32'(i_item.start_block) + 32'(i_item.block_count);
    assign n_rel_last = (n_end > 32'(MAP_BLOCKS)) ? BW'(MAP_BLOCKS - 1)
                                                  : BW'(n_end - 32'd1);

    assign w_last_word  = (r_word == WAW'(MAP_WORDS - 1));
    assign w_chunk_bits = w_rdata[{r_chunk, {bffa_pkg::CHUNK_SHIFT{1'b0}}}
                                  +: bffa_pkg::CHUNK_BITS];
    assign w_chunk_base = {r_word, r_chunk, {bffa_pkg::CHUNK_SHIFT{1'b0}}};
    assign w_alloc_hi   = w_scan_first + BW'(r_need - NW'(1));
    assign w_free_alloc = r_free - FCW'(r_need);

    // Map RAM port control: read in the read states, write on clear and merge.
    assign w_ram_re = (r_state == ST_SRD) || (r_state == ST_MRD);
    assign w_ram_we = (r_state == ST_CLR) || (r_state == ST_MWR);
    assign w_wdata  = (r_state == ST_CLR) ? '0 : w_merge;

    bffa_ram #(
        .WIDTH(bffa_pkg::WORD_BITS),
        .DEPTH(MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_word),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_word),
        .o_rdata (w_rdata)
    );

    bffa_scan #(
        .BW(BW)
    ) u_scan (
        .i_bits  (w_chunk_bits),
        .i_base  (w_chunk_base),
        .i_run   (r_run),
        .i_need  (r_need),
        .i_first (r_first),
        .o_res   (w_scan),
        .o_first (w_scan_first)
    );

    bffa_mask #(
        .BW(BW)
    ) u_mask (
        .i_word  (r_word),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_set   (r_set),
        .i_rdata (w_rdata),
        .o_wdata (w_merge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_word      <= '0;
            r_free      <= FCW'(POOL_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result beat once taken; the done state reloads it itself.
            if (r_out_valid && !i_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    if (w_last_word) begin
                        r_word  <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_word <= r_word + WAW'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        if (i_item.mode == bffa_pkg::MODE_ALLOC) begin
                            if (n_need == '0 || 32'(n_need) > 32'(r_free)) begin
                                r_res.status           <= bffa_pkg::STATUS_OOM;
                                r_res.run_start        <= '0;
                                r_res.run_blocks       <= '0;
                                r_res.free_blocks_left <= 13'(r_free);
                                r_state                <= ST_DONE;
                            end else begin
                                r_need  <= n_need;
                                r_run   <= '0;
                                r_first <= '0;
                                r_word  <= '0;
                                r_state <= ST_SRD;
                            end
                        end else if (!n_in_pool) begin
                            r_res.status           <= bffa_pkg::STATUS_RANGE;
                            r_res.run_start        <= '0;
                            r_res.run_blocks       <= '0;
                            r_res.free_blocks_left <= 13'(r_free);
                            r_state                <= ST_DONE;
                        end else begin
                            r_free                 <= n_free_rel;
                            r_res.status           <= bffa_pkg::STATUS_OK;
                            r_res.run_start        <= i_item.start_block;
                            r_res.run_blocks       <= i_item.block_count;
                            r_res.free_blocks_left <= 13'(n_free_rel);
                            // Nothing to clear for an empty run or a start past the map.
                            if (i_item.block_count == '0 || !n_in_map) begin
                                r_state <= ST_DONE;
                            end else begin
                                r_lo    <= BW'(i_item.start_block);
                                r_hi    <= n_rel_last;
                                r_set   <= 1'b0;
                                r_word  <= WAW'(i_item.start_block >> 6);
                                r_state <= ST_MRD;
                            end
                        end
                    end
                end
                ST_SRD: begin
                    r_chunk <= '0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if ((r_chunk == '0 && (&w_rdata)) ||
                        (!w_scan.hit &&
                         r_chunk == bffa_pkg::CHUNK_SHIFT'(bffa_pkg::CHUNKS - 1))) begin
                        // Full word skipped or word exhausted: advance to the next word, or fail after the last.
                        if (r_chunk == '0 && (&w_rdata)) begin
                            r_run <= '0;
                        end else begin
                            r_run   <= w_scan.run;
                            r_first <= w_scan_first;
                        end
                        if (w_last_word) begin
                            r_res.status           <= bffa_pkg::STATUS_OOM;
                            r_res.run_start        <= '0;
                            r_res.run_blocks       <= '0;
                            r_res.free_blocks_left <= 13'(r_free);
                            r_state                <= ST_DONE;
                        end else begin
                            r_word  <= r_word + WAW'(1);
                            r_state <= ST_SRD;
                        end
                    end else if (w_scan.hit) begin
                        r_lo                   <= w_scan_first;
                        r_hi                   <= w_alloc_hi;
                        r_set                  <= 1'b1;
                        r_word                 <= w_scan_first[BW-1:6];
                        r_free                 <= w_free_alloc;
                        r_res.status           <= bffa_pkg::STATUS_OK;
                        r_res.run_start        <= 12'(w_scan_first);
                        r_res.run_blocks       <= 13'(r_need);
                        r_res.free_blocks_left <= 13'(w_free_alloc);
                        r_state                <= ST_MRD;
                    end else begin
                        r_run   <= w_scan.run;
                        r_first <= w_scan_first;
                        r_chunk <= r_chunk + bffa_pkg::CHUNK_SHIFT'(1);
                    end
                end
                ST_MRD: begin
                    r_state <= ST_MWR;
                end
                ST_MWR: begin
                    if (r_word == r_hi[BW-1:6]) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_word  <= r_word + WAW'(1);
                        r_state <= ST_MRD;
                    end
                end
                ST_DONE: begin
                    // Hold until the result register is free or being emptied.
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `BFFA_ASSERT(a_free_le_pool, r_free <= FCW'(POOL_BLOCKS), "free count above pool size")
    `BFFA_ASSERT(a_accept_goes_busy, (i_valid && !o_stall) |=> o_stall, "request beat not followed by busy")
    `BFFA_ASSERT(a_fail_zero_run, (o_valid && o_result.status != bffa_pkg::STATUS_OK) |-> (o_result.run_blocks == 13'd0), "failed result carries blocks")
    `BFFA_ASSERT(a_no_write_idle, (r_state == ST_IDLE) |-> !w_ram_we, "map written while idle")

endmodule

/* tb/sv/tb_bitmap_first_fit_block_allocator.sv */
// Self-checking testbench for the bitmap first-fit block allocator: directed
// corner cases, then random allocate/free traffic under varying back-pressure.
// Depends on bffa_pkg and the bitmap_first_fit_block_allocator top level.
`timescale 1ns / 1ps

module tb_bitmap_first_fit_block_allocator;

    import bffa_pkg::*;

    localparam int unsigned POOL_BLOCKS  = 4096;
    localparam int unsigned DRAIN_CYCLES = 1000;   // longer than the slowest allocate
    localparam int unsigned PHASE_ITEMS  = 234;

    // A run handed out by the allocator that the traffic generator may free later.
    typedef struct {
        int unsigned first;
        int unsigned blocks;
    } t_grant;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_item  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_result;

    // Shadow of the allocator state, advanced once per accepted request beat.
    bit          block_used [POOL_BLOCKS];
    int unsigned pool_free_count = POOL_BLOCKS;
    int unsigned pool_used_count = 0;

    t_out        expected_results [$];
    t_grant      live_runs [$];
    t_out        want_result;
    int unsigned mismatch_count = 0;
    int unsigned gap_pct   = 0;    // chance in percent that the sender idles a cycle
    int unsigned stall_pct = 0;    // chance in percent that the receiver stalls a cycle

    bitmap_first_fit_block_allocator #(
        .POOL_BLOCKS(POOL_BLOCKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result channel at random; the rate changes between phases.
    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Compute the result of one request and advance the shadow state.
    function automatic t_out predict_result(input t_in req);
        t_out        res;
        int unsigned need;
        int unsigned run;
        int unsigned first;
        int unsigned blk;
        int unsigned stop;
        bit          found;
        res   = '0;
        run   = 0;
        first = 0;
        found = 1'b0;
        if (req.mode == MODE_ALLOC) begin
            need = (req.request_bytes + HEADER_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
            res.status = STATUS_OOM;
            // A request larger than the free count is refused without a search.
            if (need != 0 && need <= pool_free_count) begin
                // First fit from block 0; a used block restarts the run.
                for (blk = 0; blk < POOL_BLOCKS && !found; blk++) begin
                    if (block_used[blk]) begin
                        run = 0;
                    end else begin
                        if (run == 0)
                            first = blk;
                        run++;
                        found = (run == need);
                    end
                end
            end
            if (found) begin
                for (blk = first; blk < first + need; blk++)
                    block_used[blk] = 1'b1;
                pool_free_count -= need;
                pool_used_count += need;
                if (pool_used_count > POOL_BLOCKS)
                    pool_used_count = POOL_BLOCKS;
                res.status     = STATUS_OK;
                res.run_start  = first[11:0];
                res.run_blocks = need[12:0];
            end
        end else if (req.start_block >= POOL_BLOCKS) begin
            res.status = STATUS_RANGE;
        end else begin
            // Clear only what lies inside the pool, but credit the full count.
            stop = req.start_block + req.block_count;
            if (stop > POOL_BLOCKS)
                stop = POOL_BLOCKS;
            for (blk = req.start_block; blk < stop; blk++)
                block_used[blk] = 1'b0;
            pool_free_count += req.block_count;
            if (pool_free_count > POOL_BLOCKS)
                pool_free_count = POOL_BLOCKS;
            pool_used_count = (pool_used_count > req.block_count) ?
                              pool_used_count - req.block_count : 0;
            res.status     = STATUS_OK;
            res.run_start  = req.start_block;
            res.run_blocks = req.block_count;
        end
        res.free_blocks_left = pool_free_count[12:0];
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [12:0] want,
                                        input logic [12:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every result beat that leaves the block with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, got %p", $time, o_result);
                mismatch_count++;
            end else begin
                want_result = expected_results.pop_front();
                check_field("status", want_result.status, o_result.status);
                check_field("run_start", want_result.run_start, o_result.run_start);
                check_field("run_blocks", want_result.run_blocks, o_result.run_blocks);
                check_field("free_blocks_left", want_result.free_blocks_left,
                            o_result.free_blocks_left);
            end
        end
    end

    // Every field random; callers overwrite the ones that matter.
    function automatic t_in random_item();
        t_in req;
        req.mode          = 1'($urandom);
        req.request_bytes = 18'($urandom);
        req.start_block   = 12'($urandom);
        req.block_count   = 13'($urandom);
        return req;
    endfunction

    function automatic t_in alloc_item(input int unsigned bytes);
        t_in req;
        req               = random_item();
        req.mode          = MODE_ALLOC;
        req.request_bytes = 18'(bytes);
        return req;
    endfunction

    function automatic t_in free_item(input int unsigned first, input int unsigned blocks);
        t_in req;
        req             = random_item();
        req.mode        = MODE_FREE;
        req.start_block = 12'(first);
        req.block_count = 13'(blocks);
        return req;
    endfunction

    // Drive one request beat and hold it until accepted. Valid stays high on
    // return so that a back-to-back beat follows without a gap; whoever comes
    // next either drives a new beat or drops valid in the same step.
    task automatic send_item(input t_in req);
        t_out predicted;
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        predicted = predict_result(req);
        expected_results.push_back(predicted);
        if (req.mode == MODE_ALLOC && predicted.status == STATUS_OK)
            live_runs.push_back('{predicted.run_start, predicted.run_blocks});
    endtask

    // Hold off the sender until every predicted result beat has been seen.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Size rounding, oversize refusal and a whole-pool grant.
    task automatic test_alloc_sizes();
        send_item(alloc_item(0));          // header alone: one block
        send_item(alloc_item(24));         // header fills exactly one block
        send_item(alloc_item(25));         // one byte over: two blocks
        send_item(alloc_item(262143));     // largest field value, far beyond the pool
        send_item(alloc_item(131064));     // whole pool while a few blocks are taken
        send_item(free_item(0, POOL_BLOCKS));
        send_item(alloc_item(131064));     // whole pool on an empty map
        send_item(alloc_item(0));          // nothing left
        send_item(free_item(0, POOL_BLOCKS));
        wait_for_results();
    endtask

    // Free of zero blocks, past the pool end, and of blocks never taken.
    // A start outside the pool cannot be encoded at this pool size.
    task automatic test_free_corners();
        send_item(free_item(4095, 0));
        send_item(alloc_item(1000));
        send_item(free_item(4000, 8191));  // clips the map, saturates the count
        send_item(free_item(100, 5));      // blocks already free
        send_item(alloc_item(0));          // map still holds the first run
        send_item(free_item(0, POOL_BLOCKS));
        wait_for_results();
    endtask

    // Free count large enough but no contiguous run; full words get skipped.
    task automatic test_fragmented_pool();
        send_item(alloc_item(131064));
        send_item(free_item(10, 1));
        send_item(free_item(20, 1));
        send_item(alloc_item(56));         // two blocks, only single holes
        send_item(alloc_item(0));          // lands in the first hole
        send_item(free_item(300, 3));
        send_item(alloc_item(56));         // past the full words to the new hole
        wait_for_results();
        send_item(free_item(0, POOL_BLOCKS));
        wait_for_results();
    endtask

    // Mostly well-formed traffic: allocations of mixed sizes and frees of runs
    // that were granted, with a little noise of arbitrary requests.
    task automatic test_random_traffic(input int unsigned sender_pct,
                                       input int unsigned receiver_pct);
        t_in         req;
        int unsigned pick;
        int unsigned idx;
        gap_pct   = sender_pct;
        stall_pct = receiver_pct;
        repeat (PHASE_ITEMS) begin
            req  = random_item();
            pick = $urandom_range(99);
            if (pick < 4) begin
                // Keep the fully random beat as noise.
            end else if (pick < 8) begin
                req.mode        = MODE_FREE;
                req.block_count = 13'($urandom_range(1, 16));
            end else if (live_runs.size() != 0 && (pick < 45 || pool_free_count < 256)) begin
                idx = $urandom_range(live_runs.size() - 1);
                req = free_item(live_runs[idx].first, live_runs[idx].blocks);
                live_runs.delete(idx);
            end else begin
                pick = $urandom_range(99);
                if (pick < 70)
                    req = alloc_item($urandom_range(0, 600));
                else if (pick < 95)
                    req = alloc_item($urandom_range(601, 8000));
                else
                    req = alloc_item($urandom_range(8001, 131064));
            end
            send_item(req);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 16;
        stall_pct = 87;
        test_alloc_sizes();
        test_free_corners();
        test_fragmented_pool();

        live_runs.delete();
        test_random_traffic(16, 87);
        test_random_traffic(87, 16);
        test_random_traffic(0, 0);

        // Catch any stray result beat after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Bound the run well above the slowest legal completion.
    initial begin
        #60_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
